// ===== rtl/tgr_pkg.sv =====
// Shared types, codes and constants for the touch gesture recognizer.
package tgr_pkg;

  localparam int RAW_W   = 16;  // raw coordinate
  localparam int POS_W   = 10;  // scaled coordinate, 0..655
  localparam int CFG_W   = 8;
  localparam int CNT_W   = 8;
  localparam int GEST_W  = 4;
  localparam int DIR_W   = 4;
  localparam int CIRC_W  = 6;
  localparam int CIDX_W  = 2;

  // divide by 100 as multiply by reciprocal; exact for every 16-bit value
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
  localparam int RECIP_SHIFT = 23;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // gesture codes
  localparam logic [GEST_W-1:0] G_NONE  = 4'd0;
  localparam logic [GEST_W-1:0] G_RIGHT = 4'd1;
  localparam logic [GEST_W-1:0] G_LEFT  = 4'd2;
  localparam logic [GEST_W-1:0] G_UP    = 4'd3;
  localparam logic [GEST_W-1:0] G_DOWN  = 4'd4;
  localparam logic [GEST_W-1:0] G_CLICK = 4'd5;
  localparam logic [GEST_W-1:0] G_CW    = 4'd6;
  localparam logic [GEST_W-1:0] G_CCW   = 4'd7;
  localparam logic [GEST_W-1:0] G_HOLD  = 4'd8;

  // per-axis direction codes
  localparam logic [1:0] D_NONE  = 2'd0;
  localparam logic [1:0] DX_RIGHT = 2'd1;
  localparam logic [1:0] DX_LEFT  = 2'd2;
  localparam logic [1:0] DY_UP    = 2'd1;
  localparam logic [1:0] DY_DOWN  = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CLICK_TOL_X = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CLICK_TOL_Y = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HOLD_TOL    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_HOLD_COUNT  = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] click_tol_x;
    logic [CFG_W-1:0] click_tol_y;
    logic [CFG_W-1:0] hold_tol;
    logic [CFG_W-1:0] hold_count;
  } tgr_cfg_t;

  typedef struct packed {
    logic [GEST_W-1:0] gesture;
    logic              hold_active;
  } tgr_result_t;

endpackage

// ===== rtl/tgr_sample_if.sv =====
// Sample and result channel interfaces.
interface tgr_sample_if;
  import tgr_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] x_raw;
  logic [RAW_W-1:0] y_raw;
  modport source (output valid, x_raw, y_raw, input ready);
  modport sink   (input valid, x_raw, y_raw, output ready);
endinterface

interface tgr_result_if;
  import tgr_pkg::*;
  logic              valid;
  logic              ready;
  logic [GEST_W-1:0] gesture;
  logic              hold_active;
  modport source (output valid, gesture, hold_active, input ready);
  modport sink   (input valid, gesture, hold_active, output ready);
endinterface

// ===== rtl/tgr_tracker.sv =====
// Presence, direction, circle and hold tracking; computes one result per step.
module tgr_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [tgr_pkg::POS_W-1:0]    x,
  input  logic [tgr_pkg::POS_W-1:0]    y,
  input  tgr_pkg::tgr_cfg_t            cfg,
  output tgr_pkg::tgr_result_t         res_next
);
  import tgr_pkg::*;

  logic [POS_W-1:0]  last_x, last_y, origin_x, origin_y;
  logic [CNT_W-1:0]  sample_count;
  logic [DIR_W-1:0]  direction_now, direction_before;
  logic [CIRC_W-1:0] circle_progress;
  logic              hold_seen, swipe_enabled, hold_output;

  logic [POS_W-1:0]  last_x_next, last_y_next, origin_x_next, origin_y_next;
  logic [CNT_W-1:0]  sample_count_next;
  logic [DIR_W-1:0]  direction_now_next, direction_before_next;
  logic [CIRC_W-1:0] circle_progress_next;
  logic              hold_seen_next, swipe_enabled_next, hold_output_next;
  logic [GEST_W-1:0] gest;

  logic              present, was_present, counted, hold_hit;
  logic [POS_W-1:0]  hold_dx, hold_dy, net_dx, net_dy;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic dir_is(input logic [DIR_W-1:0] b, input logic [DIR_W-1:0] n,
                                  input logic [1:0] bx, input logic [1:0] nx,
                                  input logic [1:0] by, input logic [1:0] ny);
    return (b[1:0] == bx) && (n[1:0] == nx) && (b[3:2] == by) && (n[3:2] == ny);
  endfunction

  always_comb begin
    last_x_next           = x;
    last_y_next           = y;
    origin_x_next         = origin_x;
    origin_y_next         = origin_y;
    sample_count_next     = sample_count;
    direction_now_next    = direction_now;
    direction_before_next = direction_before;
    circle_progress_next  = circle_progress;
    hold_seen_next        = hold_seen;
    swipe_enabled_next    = swipe_enabled;
    hold_output_next      = hold_output;
    gest                  = G_NONE;

    present     = (x != '0) || (y != '0);
    was_present = (last_x != '0) || (last_y != '0);
    counted     = sample_count < CNT_MAX;
    net_dx      = abs_diff(last_x, origin_x);
    net_dy      = abs_diff(last_y, origin_y);
    hold_dx     = '0;
    hold_dy     = '0;
    hold_hit    = 1'b0;

    if (present) begin
      if (counted) sample_count_next = sample_count + 8'd1;
      // entering the zone: new origin, tracking starts over
      if (!was_present) begin
        hold_seen_next       = 1'b0;
        circle_progress_next = '0;
        direction_now_next   = '0;
        origin_x_next        = x;
        origin_y_next        = y;
      end
      direction_before_next = direction_now_next;

      hold_dx  = abs_diff(x, origin_x_next);
      hold_dy  = abs_diff(y, origin_y_next);
      hold_hit = counted && (sample_count_next == cfg.hold_count) &&
                 (hold_dx < {2'b00, cfg.hold_tol}) && (hold_dy < {2'b00, cfg.hold_tol});
      if (hold_hit) begin
        hold_seen_next     = 1'b1;
        gest               = G_HOLD;
        swipe_enabled_next = 1'b0;
      end

      if (!hold_seen_next) begin
        // an axis that does not move keeps its last direction
        if (x > last_x)      direction_now_next[1:0] = DX_RIGHT;
        else if (x < last_x) direction_now_next[1:0] = DX_LEFT;
        if (y > last_y)      direction_now_next[3:2] = DY_UP;
        else if (y < last_y) direction_now_next[3:2] = DY_DOWN;

        if (dir_is(direction_before_next, direction_now_next,
                   DX_RIGHT, DX_RIGHT, DY_UP, DY_DOWN))
          circle_progress_next[0] = 1'b1;
        if (circle_progress_next[0] && dir_is(direction_before_next, direction_now_next,
                   DX_RIGHT, DX_LEFT, DY_DOWN, DY_DOWN))
          circle_progress_next[1] = 1'b1;
        if (circle_progress_next[1] && dir_is(direction_before_next, direction_now_next,
                   DX_LEFT, DX_LEFT, DY_DOWN, DY_UP))
          circle_progress_next[2] = 1'b1;
        if (circle_progress_next[2] && dir_is(direction_before_next, direction_now_next,
                   DX_LEFT, DX_RIGHT, DY_UP, DY_UP)) begin
          gest                      = G_CW;
          circle_progress_next[2:0] = 3'b000;
          swipe_enabled_next        = 1'b0;
        end

        if (dir_is(direction_before_next, direction_now_next,
                   DX_LEFT, DX_LEFT, DY_UP, DY_DOWN))
          circle_progress_next[3] = 1'b1;
        if (circle_progress_next[3] && dir_is(direction_before_next, direction_now_next,
                   DX_LEFT, DX_RIGHT, DY_DOWN, DY_DOWN))
          circle_progress_next[4] = 1'b1;
        if (circle_progress_next[4] && dir_is(direction_before_next, direction_now_next,
                   DX_RIGHT, DX_RIGHT, DY_DOWN, DY_UP))
          circle_progress_next[5] = 1'b1;
        if (circle_progress_next[5] && dir_is(direction_before_next, direction_now_next,
                   DX_RIGHT, DX_LEFT, DY_UP, DY_UP)) begin
          gest                      = G_CCW;
          circle_progress_next[5:3] = 3'b000;
          swipe_enabled_next        = 1'b0;
        end
      end
    end else if (was_present) begin
      // leaving: net motion decides swipe or click
      if (swipe_enabled) begin
        if (net_dx > net_dy)      gest = (last_x > origin_x) ? G_RIGHT : G_LEFT;
        else if (net_dy > net_dx) gest = (last_y > origin_y) ? G_UP : G_DOWN;
        if ((net_dx < {2'b00, cfg.click_tol_x}) && (net_dy < {2'b00, cfg.click_tol_y}))
          gest = G_CLICK;
      end
      swipe_enabled_next = 1'b1;
      hold_output_next   = 1'b0;
      sample_count_next  = '0;
    end

    if (gest == G_HOLD) hold_output_next = 1'b1;

    res_next.gesture     = gest;
    res_next.hold_active = hold_output_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x           <= '0;
      last_y           <= '0;
      origin_x         <= '0;
      origin_y         <= '0;
      sample_count     <= '0;
      direction_now    <= '0;
      direction_before <= '0;
      circle_progress  <= '0;
      hold_seen        <= 1'b0;
      swipe_enabled    <= 1'b1;
      hold_output      <= 1'b0;
    end else if (step) begin
      last_x           <= last_x_next;
      last_y           <= last_y_next;
      origin_x         <= origin_x_next;
      origin_y         <= origin_y_next;
      sample_count     <= sample_count_next;
      direction_now    <= direction_now_next;
      direction_before <= direction_before_next;
      circle_progress  <= circle_progress_next;
      hold_seen        <= hold_seen_next;
      swipe_enabled    <= swipe_enabled_next;
      hold_output      <= hold_output_next;
    end
  end

endmodule

// ===== rtl/touch_gesture_recognizer.sv =====
// Touch gesture recognizer: one position word in, one gesture word out.
//
// Each accepted sample word is scaled by 1/100 (reciprocal multiply) into an
// input register; once the output register is free, the tracking state is
// updated and the result word is loaded into the output register, so a
// result passes through the input and output registers. A new sample is
// taken every cycle as long as the output register is empty or being
// drained; the throughput is then one word per clock. Configuration
// writes are taken at any time through cfg_we/cfg_index/cfg_data and are
// meant to happen while no sample is in flight.
module touch_gesture_recognizer (
  input  logic                         clk,
  input  logic                         rst,
  tgr_sample_if.sink                   sample,
  tgr_result_if.source                 result,
  input  logic                         cfg_we,
  input  logic [tgr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tgr_pkg::CFG_W-1:0]    cfg_data
);
  import tgr_pkg::*;

  localparam int PROD_W = RAW_W + RECIP_W;

  tgr_cfg_t          cfg;
  logic              s1_valid;
  logic [POS_W-1:0]  s1_x, s1_y;
  logic              out_valid;
  tgr_result_t       res;
  tgr_result_t       res_next;
  logic              out_free, step;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign prod_x = PROD_W'(sample.x_raw) * PROD_W'(RECIP_100);
  assign prod_y = PROD_W'(sample.y_raw) * PROD_W'(RECIP_100);

  assign out_free     = !out_valid || result.ready;
  assign step         = s1_valid && out_free;
  assign sample.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_tol_x <= 8'd5;
      cfg.click_tol_y <= 8'd5;
      cfg.hold_tol    <= 8'd8;
      cfg.hold_count  <= 8'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLICK_TOL_X: cfg.click_tol_x <= cfg_data;
        CFG_CLICK_TOL_Y: cfg.click_tol_y <= cfg_data;
        CFG_HOLD_TOL:    cfg.hold_tol    <= cfg_data;
        CFG_HOLD_COUNT:  cfg.hold_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s1_x <= prod_x[RECIP_SHIFT +: POS_W];
      s1_y <= prod_y[RECIP_SHIFT +: POS_W];
    end
  end

  tgr_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .x        (s1_x),
    .y        (s1_y),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
  end

  assign result.valid       = out_valid;
  assign result.gesture     = res.gesture;
  assign result.hold_active = res.hold_active;

endmodule
